[hw/rtl/cfp_pkg.sv]
// ---------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants for the command frame parser.
// ---------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned N_FIELDS  = 8;
    localparam int unsigned IDX_W     = $clog2(N_FIELDS);

    localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'hFF;
    localparam logic [IDX_W-1:0]  FIELD_LAST = IDX_W'(N_FIELDS - 1);

    // Field slots, in arrival order
    localparam logic [IDX_W-1:0] F_MODE     = 3'd0;
    localparam logic [IDX_W-1:0] F_TYPE     = 3'd1;
    localparam logic [IDX_W-1:0] F_SET_TYPE = 3'd2;
    localparam logic [IDX_W-1:0] F_ANGLE    = 3'd3;
    localparam logic [IDX_W-1:0] F_X_FIRST  = 3'd4;
    localparam logic [IDX_W-1:0] F_X_SECOND = 3'd5;
    localparam logic [IDX_W-1:0] F_Y_FIRST  = 3'd6;
    localparam logic [IDX_W-1:0] F_Y_SECOND = 3'd7;

    typedef enum logic [2:0] {
        ST_HUNT0,
        ST_HUNT1,
        ST_FIELD,
        ST_CHK_HI,
        ST_CHK_LO
    } cfp_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] mode;
        logic [BYTE_W-1:0] item_type;
        logic [BYTE_W-1:0] set_type;
        logic [BYTE_W-1:0] angle;
        logic [BYTE_W-1:0] x_first;
        logic [BYTE_W-1:0] x_second;
        logic [BYTE_W-1:0] y_first;
        logic [BYTE_W-1:0] y_second;
    } cfp_fields_t;

    typedef struct packed {
        logic last_byte;   // current byte is the check low byte
        logic hunting;     // waiting for the first header byte
    } cfp_status_t;

endpackage

`default_nettype wire

[hw/rtl/cfp_frame_store.sv]
// ---------------------------------------------------------------------------
// cfp_frame_store
// Byte position tracker and storage for frame fields and check high byte.
// ---------------------------------------------------------------------------
`default_nettype none

module cfp_frame_store (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         byte_valid,
    input  wire logic [cfp_pkg::BYTE_W-1:0]   byte_in,
    output cfp_pkg::cfp_fields_t              fields,
    output logic [cfp_pkg::BYTE_W-1:0]        check_high,
    output cfp_pkg::cfp_status_t              status
);

    cfp_pkg::cfp_state_t               state_reg, state_next;
    logic [cfp_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic [cfp_pkg::BYTE_W-1:0]        field_reg [cfp_pkg::N_FIELDS];
    logic [cfp_pkg::BYTE_W-1:0]        check_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cfp_pkg::ST_HUNT0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        if (byte_valid) begin
            unique case (state_reg)
                cfp_pkg::ST_HUNT0: begin
                    state_next = (byte_in == cfp_pkg::HDR_BYTE) ?
                                 cfp_pkg::ST_HUNT1 : cfp_pkg::ST_HUNT0;
                end
                cfp_pkg::ST_HUNT1: begin
                    state_next = (byte_in == cfp_pkg::HDR_BYTE) ?
                                 cfp_pkg::ST_FIELD : cfp_pkg::ST_HUNT0;
                    idx_next   = '0;
                end
                cfp_pkg::ST_FIELD: begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == cfp_pkg::FIELD_LAST) begin
                        state_next = cfp_pkg::ST_CHK_HI;
                    end
                end
                cfp_pkg::ST_CHK_HI: begin
                    state_next = cfp_pkg::ST_CHK_LO;
                end
                cfp_pkg::ST_CHK_LO: begin
                    state_next = cfp_pkg::ST_HUNT0;
                end
                default: begin
                    state_next = cfp_pkg::ST_HUNT0;
                end
            endcase
        end
    end

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        if (byte_valid && state_reg == cfp_pkg::ST_FIELD) begin
            field_reg[idx_reg] <= byte_in;
        end
        if (byte_valid && state_reg == cfp_pkg::ST_CHK_HI) begin
            check_high_reg <= byte_in;
        end
    end

    assign fields.mode      = field_reg[cfp_pkg::F_MODE];
    assign fields.item_type = field_reg[cfp_pkg::F_TYPE];
    assign fields.set_type  = field_reg[cfp_pkg::F_SET_TYPE];
    assign fields.angle     = field_reg[cfp_pkg::F_ANGLE];
    assign fields.x_first   = field_reg[cfp_pkg::F_X_FIRST];
    assign fields.x_second  = field_reg[cfp_pkg::F_X_SECOND];
    assign fields.y_first   = field_reg[cfp_pkg::F_Y_FIRST];
    assign fields.y_second  = field_reg[cfp_pkg::F_Y_SECOND];
    assign check_high       = check_high_reg;

    assign status.last_byte = (state_reg == cfp_pkg::ST_CHK_LO);
    assign status.hunting   = (state_reg == cfp_pkg::ST_HUNT0);

endmodule

`default_nettype wire

[hw/rtl/cfp_check.sv]
// ---------------------------------------------------------------------------
// cfp_check
// Computes |(X + Y bytes) - (mode + type + set type + angle) + 1| and
// compares it with the received check word.
// ---------------------------------------------------------------------------
`default_nettype none

module cfp_check (
    input  wire cfp_pkg::cfp_fields_t         fields,
    input  wire logic [cfp_pkg::BYTE_W-1:0]   check_high,
    input  wire logic [cfp_pkg::BYTE_W-1:0]   check_low,
    output logic                              passed
);

    localparam int unsigned SUM_W = cfp_pkg::BYTE_W + 2;   // four bytes
    localparam int unsigned DIF_W = SUM_W + 2;             // signed, with +1

    logic [SUM_W-1:0]        pos_sum;
    logic [SUM_W-1:0]        neg_sum;
    logic signed [DIF_W-1:0] diff;
    logic [DIF_W-1:0]        mag;
    logic [cfp_pkg::BYTE_W-1:0] mag_hi;
    logic [cfp_pkg::BYTE_W-1:0] mag_lo;

    always_comb begin
        pos_sum = SUM_W'(fields.x_first) + SUM_W'(fields.x_second)
                + SUM_W'(fields.y_first) + SUM_W'(fields.y_second);
        neg_sum = SUM_W'(fields.mode) + SUM_W'(fields.item_type)
                + SUM_W'(fields.set_type) + SUM_W'(fields.angle);
        diff    = $signed(DIF_W'(pos_sum)) - $signed(DIF_W'(neg_sum))
                + $signed(DIF_W'(1));
        mag     = diff[DIF_W-1] ? DIF_W'(-diff) : DIF_W'(diff);
        // magnitude stays below 1024, so the high byte is 0..3
        mag_hi  = cfp_pkg::BYTE_W'(mag[DIF_W-1:cfp_pkg::BYTE_W]);
        mag_lo  = mag[cfp_pkg::BYTE_W-1:0];
        passed  = (mag_hi == check_high) && (mag_lo == check_low);
    end

endmodule

`default_nettype wire

[hw/rtl/command_frame_parser.sv]
// ---------------------------------------------------------------------------
// command_frame_parser
// Serial command frame parser: header hunt, field capture, check word test.
// ---------------------------------------------------------------------------
// Result path: a frame's last byte is held in the input register, then its
//   result is loaded into the result register once that register is free.
// Throughput: 1 byte per cycle; input stalls only while a frame's last byte
//   waits on a result register that has not been taken.
// Reset (aresetn low, synchronous): parser hunts for the first header byte,
//   input and result registers empty. Field storage is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module command_frame_parser (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [cfp_pkg::BYTE_W-1:0]   s_rx_byte,

    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [cfp_pkg::BYTE_W-1:0]        m_mode,
    output logic [cfp_pkg::BYTE_W-1:0]        m_item_type,
    output logic [cfp_pkg::BYTE_W-1:0]        m_set_type,
    output logic [cfp_pkg::BYTE_W-1:0]        m_angle,
    output logic [cfp_pkg::BYTE_W-1:0]        m_x_first,
    output logic [cfp_pkg::BYTE_W-1:0]        m_x_second,
    output logic [cfp_pkg::BYTE_W-1:0]        m_y_first,
    output logic [cfp_pkg::BYTE_W-1:0]        m_y_second,
    output logic                              m_check_passed
);

    // input register: one word waiting to be parsed
    logic                        in_valid_reg;
    logic [cfp_pkg::BYTE_W-1:0]  in_byte_reg;

    // result register
    logic                        m_valid_reg;
    cfp_pkg::cfp_fields_t        out_fields_reg;
    logic                        out_passed_reg;

    cfp_pkg::cfp_fields_t        fields;
    cfp_pkg::cfp_status_t        status;
    logic [cfp_pkg::BYTE_W-1:0]  check_high;
    logic                        passed;

    logic                        out_free;   // result slot empty or draining
    logic                        advance;    // parse the held word this cycle
    logic                        out_load;   // word completes a frame

    // A word that completes a frame needs the result slot; any other word
    // is consumed unconditionally.
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!status.last_byte || out_free);
    assign out_load = advance && status.last_byte;
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    cfp_frame_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (advance),
        .byte_in    (in_byte_reg),
        .fields     (fields),
        .check_high (check_high),
        .status     (status)
    );

    // the held word is the check low byte when it completes a frame
    cfp_check u_check (
        .fields     (fields),
        .check_high (check_high),
        .check_low  (in_byte_reg),
        .passed     (passed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_fields_reg <= fields;
            out_passed_reg <= passed;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mode         = out_fields_reg.mode;
    assign m_item_type    = out_fields_reg.item_type;
    assign m_set_type     = out_fields_reg.set_type;
    assign m_angle        = out_fields_reg.angle;
    assign m_x_first      = out_fields_reg.x_first;
    assign m_x_second     = out_fields_reg.x_second;
    assign m_y_first      = out_fields_reg.y_first;
    assign m_y_second     = out_fields_reg.y_second;
    assign m_check_passed = out_passed_reg;

    // completed frame always lands in the result register
    a_frame_emitted: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("completed frame not presented");

    // parser returns to hunting after every frame, pass or fail
    a_back_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> status.hunting)
        else $error("parser did not return to hunting");

    // a stalled input word is held, not dropped
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held input word lost");

endmodule

`default_nettype wire

[dv/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for command_frame_parser: streams serial bytes (mostly
// well-formed command frames, plus noise and cut-off frames) through the
// valid/ready input, predicts every emitted frame and compares it field by
// field on the result side, under three sender/receiver back-pressure mixes.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Parser byte positions: two header hunts, eight field bytes, check hi/lo
    localparam logic [3:0] POS_HUNT0  = 4'd0;
    localparam logic [3:0] POS_HUNT1  = 4'd1;
    localparam logic [3:0] POS_FIELD0 = 4'd2;
    localparam logic [3:0] POS_CHK_HI = 4'd10;
    localparam logic [3:0] POS_CHK_LO = 4'd11;

    localparam int PHASE_BYTES  = 400;   // frame bytes per back-pressure phase
    localparam int STALL_LIMIT  = 2000;  // cycles without any accepted word
    localparam int DRAIN_CYCLES = 8;     // settle margin after the last frame

    typedef struct packed {
        cfp_pkg::cfp_fields_t fields;
        logic                 passed;
    } frame_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;

    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [7:0]  m_mode;
    logic [7:0]  m_item_type;
    logic [7:0]  m_set_type;
    logic [7:0]  m_angle;
    logic [7:0]  m_x_first;
    logic [7:0]  m_x_second;
    logic [7:0]  m_y_first;
    logic [7:0]  m_y_second;
    logic        m_check_passed;

    // Stimulus and scoreboard state
    logic [7:0]    rx_byte_q [$];    // bytes still to be sent
    frame_result_t frame_q [$];      // frames the parser still owes us
    int            bytes_queued   = 0;
    int            bytes_accepted = 0;
    int            mismatch_cnt   = 0;
    int            tx_idle_pct    = 0;
    int            rx_idle_pct    = 0;
    int            stall_cnt      = 0;

    // Shadow copy of the parser state
    logic [3:0]    byte_pos = POS_HUNT0;
    logic [7:0]    frame_bytes [cfp_pkg::N_FIELDS];
    logic [7:0]    chk_hi;

    command_frame_parser u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mode         (m_mode),
        .m_item_type    (m_item_type),
        .m_set_type     (m_set_type),
        .m_angle        (m_angle),
        .m_x_first      (m_x_first),
        .m_x_second     (m_x_second),
        .m_y_first      (m_y_first),
        .m_y_second     (m_y_second),
        .m_check_passed (m_check_passed)
    );

    always #1 aclk = ~aclk;

    // Check word: |(X and Y bytes) - (mode, type, set type, angle) + 1|.
    // Largest magnitude is 1021, so the high byte never exceeds 3.
    function automatic logic [15:0] frame_check_word(input cfp_pkg::cfp_fields_t f);
        int sum_xy;
        int sum_cmd;
        int diff;
        sum_xy  = int'(f.x_first) + int'(f.x_second) + int'(f.y_first) + int'(f.y_second);
        sum_cmd = int'(f.mode) + int'(f.item_type) + int'(f.set_type) + int'(f.angle);
        diff    = sum_xy - sum_cmd + 1;
        if (diff < 0) begin
            diff = -diff;
        end
        return 16'(diff);
    endfunction

    // Advance the shadow parser by one accepted byte; queue a frame on the
    // check low byte.
    task automatic parse_rx_byte(input logic [7:0] b);
        frame_result_t res;
        if (byte_pos <= POS_HUNT1) begin
            // Anything but a header byte while hunting drops back to the start
            byte_pos = (b == cfp_pkg::HDR_BYTE) ? byte_pos + 4'd1 : POS_HUNT0;
        end else if (byte_pos < POS_CHK_HI) begin
            frame_bytes[3'(byte_pos - POS_FIELD0)] = b;
            byte_pos = byte_pos + 4'd1;
        end else if (byte_pos == POS_CHK_HI) begin
            chk_hi   = b;
            byte_pos = POS_CHK_LO;
        end else if (byte_pos == POS_CHK_LO) begin
            res.fields.mode      = frame_bytes[cfp_pkg::F_MODE];
            res.fields.item_type = frame_bytes[cfp_pkg::F_TYPE];
            res.fields.set_type  = frame_bytes[cfp_pkg::F_SET_TYPE];
            res.fields.angle     = frame_bytes[cfp_pkg::F_ANGLE];
            res.fields.x_first   = frame_bytes[cfp_pkg::F_X_FIRST];
            res.fields.x_second  = frame_bytes[cfp_pkg::F_X_SECOND];
            res.fields.y_first   = frame_bytes[cfp_pkg::F_Y_FIRST];
            res.fields.y_second  = frame_bytes[cfp_pkg::F_Y_SECOND];
            // A failed check still emits the frame, then the hunt restarts
            res.passed = (frame_check_word(res.fields) == {chk_hi, b});
            frame_q.push_back(res);
            byte_pos = POS_HUNT0;
        end else begin
            byte_pos = POS_HUNT0;
        end
    endtask

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    task automatic queue_byte(input logic [7:0] b);
        rx_byte_q.push_back(b);
        bytes_queued++;
    endtask

    // Two headers, the eight field bytes in arrival order, check word hi first
    task automatic queue_frame(input cfp_pkg::cfp_fields_t f, input logic [15:0] word);
        queue_byte(cfp_pkg::HDR_BYTE);
        queue_byte(cfp_pkg::HDR_BYTE);
        queue_byte(f.mode);
        queue_byte(f.item_type);
        queue_byte(f.set_type);
        queue_byte(f.angle);
        queue_byte(f.x_first);
        queue_byte(f.x_second);
        queue_byte(f.y_first);
        queue_byte(f.y_second);
        queue_byte(word[15:8]);
        queue_byte(word[7:0]);
    endtask

    // Field content leaning on the extremes now and then
    function automatic logic [7:0] rand_field_byte();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0) begin
            return 8'h00;
        end else if (pick == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic cfp_pkg::cfp_fields_t rand_fields();
        cfp_pkg::cfp_fields_t f;
        f.mode      = rand_field_byte();
        f.item_type = rand_field_byte();
        f.set_type  = rand_field_byte();
        f.angle     = rand_field_byte();
        f.x_first   = rand_field_byte();
        f.x_second  = rand_field_byte();
        f.y_first   = rand_field_byte();
        f.y_second  = rand_field_byte();
        return f;
    endfunction

    // Random traffic: mostly good frames, some with a corrupted check word,
    // some line noise and some frames cut short after the headers.
    task automatic queue_random_traffic(input int n_bytes);
        cfp_pkg::cfp_fields_t f;
        logic [15:0] word;
        int          sent;
        int          pick;
        int          cut;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(99);
            f    = rand_fields();
            word = frame_check_word(f);
            if (pick < 68) begin
                queue_frame(f, word);
                sent += 12;
            end else if (pick < 78) begin
                // any nonzero flip breaks the check
                queue_frame(f, word ^ 16'($urandom_range(1, 65535)));
                sent += 12;
            end else if (pick < 84) begin
                // only the low bit of the low byte off by one
                queue_frame(f, word ^ 16'h0001);
                sent += 12;
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(255)));
            end else begin
                // headers then a few bytes; the rest spills into the next frame
                cut = $urandom_range(0, 9);
                queue_byte(cfp_pkg::HDR_BYTE);
                queue_byte(cfp_pkg::HDR_BYTE);
                repeat (cut) queue_byte(rand_field_byte());
                sent += cut + 2;
            end
        end
    endtask

    // Driver: one byte word per handshake. Valid is only dropped when the
    // current word went through (or none was pending), never while waiting.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_rx_byte(s_rx_byte);
                bytes_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (rx_byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= rx_byte_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted frame with the oldest prediction, and
    // toggle ready at the current receiver stall rate.
    always @(posedge aclk) begin : monitor
        frame_result_t want;
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (frame_q.size() == 0) begin
                $display("%0t: unexpected frame, expected none, got %h pass=%0b",
                         $time, {m_mode, m_item_type, m_set_type, m_angle,
                         m_x_first, m_x_second, m_y_first, m_y_second},
                         m_check_passed);
                mismatch_cnt++;
            end else begin
                want = frame_q.pop_front();
                report_field("mode",         want.fields.mode,      m_mode);
                report_field("item_type",    want.fields.item_type, m_item_type);
                report_field("set_type",     want.fields.set_type,  m_set_type);
                report_field("angle",        want.fields.angle,     m_angle);
                report_field("x_first",      want.fields.x_first,   m_x_first);
                report_field("x_second",     want.fields.x_second,  m_x_second);
                report_field("y_first",      want.fields.y_first,   m_y_first);
                report_field("y_second",     want.fields.y_second,  m_y_second);
                report_field("check_passed", 8'(want.passed),       8'(m_check_passed));
            end
        end
    end

    // Watchdog: a stretch with no word moving on either side means a hang
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin : stimulus
        cfp_pkg::cfp_fields_t f;
        logic [15:0]          word;
        int                   phase;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: a header then a non-header restarts the hunt (both dropped)
        queue_byte(cfp_pkg::HDR_BYTE);
        queue_byte(8'h00);
        // A third 0xFF is the mode byte; command bytes all-ones, X/Y all-zero,
        // most negative difference, correct check word 0x03FB
        f = '{mode: 8'hFF, item_type: 8'hFF, set_type: 8'hFF, angle: 8'hFF,
              x_first: 8'h00, x_second: 8'h00, y_first: 8'h00, y_second: 8'h00};
        queue_frame(f, frame_check_word(f));
        // Largest magnitude 0x03FD; high check byte above 3 can never match
        f = '{mode: 8'h00, item_type: 8'h00, set_type: 8'h00, angle: 8'h00,
              x_first: 8'hFF, x_second: 8'hFF, y_first: 8'hFF, y_second: 8'hFF};
        word = frame_check_word(f);
        queue_frame(f, {8'hFF, word[7:0]});

        // Back-pressure mixes: slow receiver, slow sender, then full speed
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 10;
                    rx_idle_pct = 65;
                end
                1: begin
                    tx_idle_pct = 65;
                    rx_idle_pct = 10;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            queue_random_traffic(PHASE_BYTES);
            while (rx_byte_q.size() != 0) @(posedge aclk);
        end

        // Drain: every byte taken, every predicted frame seen, then settle
        while (bytes_accepted != bytes_queued) @(posedge aclk);
        while (frame_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
